>>> sv/agtf_pkg.sv
// package: types, constants and coefficient tables of the gravity torque unit
package agtf_pkg;

  localparam int VW = 37;
  localparam int DW = 52;
  localparam int FRAC = 12;

  typedef logic signed [VW-1:0] val_t;

  localparam val_t SAT_LIM = val_t'(64'sd68719476735);
  localparam logic signed [17:0] K_FORE = -18'sd33395;
  localparam logic signed [17:0] K_UPPER = 18'sd66266;

  localparam int FA_HI = 7682;
  localparam int FA_LO = 358;
  localparam int UA_HI = 9959;
  localparam int UA_LO = -5053;

  localparam val_t FORE_COEF [4][3] = '{
    '{val_t'(0), val_t'(0), val_t'(0)},
    '{val_t'(426750), val_t'(-745513), val_t'(-1727177)},
    '{val_t'(339292), val_t'(-534979), val_t'(-1792000)},
    '{val_t'(286720), val_t'(-491930), val_t'(-1539500)}
  };
  localparam val_t UPPER_COEF [2][3] = '{
    '{val_t'(-285118), val_t'(28095), val_t'(2474853)},
    '{val_t'(-295865), val_t'(151429), val_t'(2171781)}
  };

  typedef enum logic [2:0] {
    REG_ARM_SELECT  = 3'd0,
    REG_FORE_PROF   = 3'd1,
    REG_UPPER_PROF  = 3'd2,
    REG_RAMP_LEN    = 3'd3,
    REG_GAIN_RU     = 3'd4,
    REG_GAIN_LU     = 3'd5,
    REG_GAIN_RF     = 3'd6,
    REG_GAIN_LF     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ARM_RIGHT = 2'd0,
    ARM_LEFT  = 2'd1,
    ARM_BOTH  = 2'd2,
    ARM_NONE  = 2'd3
  } arm_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_MUL,
    S_WB,
    S_DIV,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    ST_F0, ST_F1, ST_F2, ST_FK,
    ST_U0, ST_U1, ST_U2, ST_UK,
    ST_UADD, ST_GF, ST_GU
  } step_e;

  function automatic logic [15:0] to_out16(input val_t t);
    logic [VW-1:0] mag;
    logic [VW-1:0] sh;
    logic [15:0] res;
    mag = t[VW-1] ? VW'(-t) : VW'(t);
    sh = mag >> FRAC;
    if (!t[VW-1]) begin
      res = (sh > VW'(32767)) ? 16'h7fff : sh[15:0];
    end else begin
      res = (sh > VW'(32768)) ? 16'h8000 : 16'(-sh[15:0]);
    end
    return res;
  endfunction

endpackage

>>> sv/arm_gravity_torque_feedforward_unit.sv
// top level: gravity torque feed-forward with one bit-serial multiplier and a serial divider
// the multiplier serves every product in turn; while soft-start scaling applies, each of
//   the four torques is also multiplied by the elapsed time and divided by the ramp length
// products come from the shift-add multiplier (one bit per cycle), quotients from the restoring divider
// a new request is taken only in idle, not while a request is in work or a result waits
// reset: async active low; control and config registers take their defaults, soft-start inactive
module arm_gravity_torque_feedforward_unit #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          hold_switch_i,
  input  logic [15:0]                   now_ms_i,
  input  logic signed [ANGLE_WIDTH-1:0] right_upper_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] left_upper_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] right_fore_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] left_fore_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            right_upper_torque_o,
  output logic signed [15:0]            left_upper_torque_o,
  output logic signed [15:0]            right_fore_torque_o,
  output logic signed [15:0]            left_fore_torque_o
);
  import agtf_pkg::*;

  localparam int MB = (ANGLE_WIDTH + 1 > 18) ? ANGLE_WIDTH + 1 : 18;
  localparam int PW = VW + MB;
  localparam int CW = $clog2(MB);
  localparam int DCW = $clog2(DW);

  state_e state_q, state_d;
  step_e  step_q;
  logic   ph_q, arm_q;
  logic [1:0] j_q;
  logic [CW-1:0] cnt_q;
  logic [DCW-1:0] dcnt_q;
  logic ramp_active_q;
  logic [15:0] ramp_start_q;
  logic [1:0] arm_sel_q, fore_prof_q, upper_prof_q;
  logic [15:0] ramp_len_q, gain_ru_q, gain_lu_q, gain_rf_q, gain_lf_q;

  logic signed [ANGLE_WIDTH-1:0] ru_q, lu_q, rf_q, lf_q;
  logic hold_q, ramp_on_q;
  logic [15:0] elapsed_q;
  logic signed [PW-1:0] acc_q, ash_q;
  logic signed [MB-1:0] bsh_q;
  val_t p_q, fore_q, upper_q;
  val_t tq_q [4];
  logic [DW-1:0] dq_q;
  logic [16:0] rem_q;
  logic neg_q;

  logic in_fire, out_fire, mul_last, div_last;
  logic signed [ANGLE_WIDTH:0] tsum;
  logic signed [ANGLE_WIDTH-1:0] xang;
  val_t fc [3];
  val_t uc [3];
  val_t a_sel, add_sel, fore_in, post_val, upper_sum, div_val;
  logic signed [MB-1:0] b_sel;
  logic signed [PW-1:0] shifted, mul_term, acc_abs;
  logic [15:0] elapsed_d;
  logic [16:0] rem_sh, rem_n;
  logic ge;
  logic [DW-1:0] dq_n;
  logic fore_lim, right_on, left_on;
  logic z_ru, z_lu, z_rf, z_lf;

  function automatic val_t sat_val(input logic signed [PW:0] x);
    val_t r;
    if (x > (PW+1)'(SAT_LIM)) begin
      r = SAT_LIM;
    end else if (x < -(PW+1)'(SAT_LIM)) begin
      r = -SAT_LIM;
    end else begin
      r = x[VW-1:0];
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign mul_last = (cnt_q == CW'(MB - 1));
  assign div_last = (dcnt_q == DCW'(DW - 1));

  // operand selection for the current step
  always_comb begin
    fc = FORE_COEF[fore_prof_q];
    uc = UPPER_COEF[upper_prof_q != 2'd1];
    tsum = arm_q ? ((ANGLE_WIDTH+1)'(lu_q) + (ANGLE_WIDTH+1)'(lf_q))
                 : ((ANGLE_WIDTH+1)'(ru_q) + (ANGLE_WIDTH+1)'(rf_q));
    xang = arm_q ? lu_q : ru_q;
    a_sel = p_q;
    b_sel = MB'(tsum);
    add_sel = '0;
    if (ph_q) begin
      a_sel = tq_q[j_q];
      b_sel = MB'({1'b0, elapsed_q});
    end else begin
      case (step_q)
        ST_F0: begin
          a_sel = fc[0];
          add_sel = fc[1];
        end
        ST_F1: add_sel = fc[2];
        ST_F2: ;
        ST_FK: b_sel = MB'(K_FORE);
        ST_U0: begin
          a_sel = uc[0];
          b_sel = MB'(xang);
          add_sel = uc[1];
        end
        ST_U1: begin
          b_sel = MB'(xang);
          add_sel = uc[2];
        end
        ST_U2: b_sel = MB'(xang);
        ST_UK: b_sel = MB'(K_UPPER);
        ST_GF: begin
          a_sel = fore_q;
          b_sel = MB'({1'b0, arm_q ? gain_lf_q : gain_rf_q});
        end
        ST_GU: begin
          a_sel = upper_q;
          b_sel = MB'({1'b0, arm_q ? gain_lu_q : gain_ru_q});
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    fore_lim = arm_q ? (int'(lf_q) <= FA_LO) : (int'(rf_q) >= FA_HI);
    fore_in = (arm_sel_q == ARM_BOTH || !fore_lim) ? fore_q : '0;
    upper_sum = sat_val((PW+1)'(fore_in) + (PW+1)'(p_q));
    shifted = acc_q >>> FRAC;
    post_val = sat_val((PW+1)'(shifted) + (PW+1)'(add_sel));
    mul_term = mul_last ? -ash_q : ash_q;
    acc_abs = acc_q[PW-1] ? -acc_q : acc_q;
    rem_sh = {rem_q[15:0], dq_q[DW-1]};
    ge = (rem_sh >= {1'b0, ramp_len_q});
    rem_n = ge ? (rem_sh - {1'b0, ramp_len_q}) : rem_sh;
    dq_n = {dq_q[DW-2:0], ge};
    div_val = neg_q ? -val_t'(dq_n[VW-1:0]) : val_t'(dq_n[VW-1:0]);
    elapsed_d = ramp_active_q ? (now_ms_i - ramp_start_q) : 16'd0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_OP;
      S_OP: begin
        if (ph_q) begin
          state_d = ramp_on_q ? S_MUL : S_DONE;
        end else if (step_q != ST_UADD) begin
          state_d = S_MUL;
        end
      end
      S_MUL: if (mul_last) state_d = S_WB;
      S_WB: state_d = ph_q ? S_DIV : S_OP;
      S_DIV: if (div_last) state_d = (j_q == 2'd3) ? S_DONE : S_OP;
      S_DONE: if (out_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= ST_F0;
      ph_q <= 1'b0;
      arm_q <= 1'b0;
      j_q <= '0;
      cnt_q <= '0;
      dcnt_q <= '0;
      ramp_active_q <= 1'b0;
      ramp_start_q <= '0;
      arm_sel_q <= ARM_BOTH;
      fore_prof_q <= 2'd3;
      upper_prof_q <= 2'd2;
      ramp_len_q <= 16'd100;
      gain_ru_q <= 16'd4096;
      gain_lu_q <= 16'd4096;
      gain_rf_q <= 16'd4096;
      gain_lf_q <= 16'd4096;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          REG_ARM_SELECT: arm_sel_q <= cfg_data_i[1:0];
          REG_FORE_PROF:  fore_prof_q <= cfg_data_i[1:0];
          REG_UPPER_PROF: upper_prof_q <= cfg_data_i[1:0];
          REG_RAMP_LEN:   ramp_len_q <= cfg_data_i;
          REG_GAIN_RU:    gain_ru_q <= cfg_data_i;
          REG_GAIN_LU:    gain_lu_q <= cfg_data_i;
          REG_GAIN_RF:    gain_rf_q <= cfg_data_i;
          REG_GAIN_LF:    gain_lf_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            ph_q <= 1'b0;
            arm_q <= 1'b0;
            step_q <= ST_F0;
            j_q <= '0;
            if (hold_switch_i) begin
              ramp_active_q <= 1'b0;
            end else if (!ramp_active_q) begin
              ramp_active_q <= 1'b1;
              ramp_start_q <= now_ms_i;
            end
          end
        end
        S_OP: begin
          cnt_q <= '0;
          if (!ph_q && step_q == ST_UADD) step_q <= step_e'(step_q + 4'd1);
        end
        S_MUL: cnt_q <= cnt_q + CW'(1);
        S_WB: begin
          dcnt_q <= '0;
          if (!ph_q) begin
            if (step_q == ST_GU) begin
              if (arm_q) begin
                ph_q <= 1'b1;
                j_q <= '0;
              end else begin
                arm_q <= 1'b1;
                step_q <= ST_F0;
              end
            end else begin
              step_q <= step_e'(step_q + 4'd1);
            end
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + DCW'(1);
          if (div_last) j_q <= j_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          ru_q <= right_upper_angle_i;
          lu_q <= left_upper_angle_i;
          rf_q <= right_fore_angle_i;
          lf_q <= left_fore_angle_i;
          hold_q <= hold_switch_i;
          elapsed_q <= elapsed_d;
          ramp_on_q <= !hold_switch_i && (elapsed_d < ramp_len_q);
        end
      end
      S_OP: begin
        if (!ph_q && step_q == ST_UADD) begin
          upper_q <= upper_sum;
        end else begin
          acc_q <= '0;
          ash_q <= PW'(a_sel);
          bsh_q <= b_sel;
        end
      end
      S_MUL: begin
        if (bsh_q[0]) acc_q <= acc_q + mul_term;
        ash_q <= ash_q <<< 1;
        bsh_q <= bsh_q >>> 1;
      end
      S_WB: begin
        if (ph_q) begin
          dq_q <= acc_abs[DW-1:0];
          rem_q <= '0;
          neg_q <= acc_q[PW-1];
        end else begin
          case (step_q)
            ST_FK: fore_q <= post_val;
            ST_GF: tq_q[{1'b1, arm_q}] <= post_val;
            ST_GU: tq_q[{1'b0, arm_q}] <= post_val;
            default: p_q <= post_val;
          endcase
        end
      end
      S_DIV: begin
        rem_q <= rem_n;
        dq_q <= dq_n;
        if (div_last) tq_q[j_q] <= div_val;
      end
      default: ;
    endcase
  end

  // joint masks: hold, arm selection, joint limits
  always_comb begin
    right_on = (arm_sel_q == ARM_RIGHT) || (arm_sel_q == ARM_BOTH);
    left_on  = (arm_sel_q == ARM_LEFT) || (arm_sel_q == ARM_BOTH);
    z_ru = hold_q || !right_on || (int'(ru_q) >= UA_HI);
    z_rf = hold_q || !right_on || (int'(rf_q) >= FA_HI);
    z_lu = hold_q || !left_on || (int'(lu_q) <= UA_LO);
    z_lf = hold_q || !left_on || (int'(lf_q) <= FA_LO);
    right_upper_torque_o = z_ru ? 16'sd0 : signed'(to_out16(tq_q[0]));
    left_upper_torque_o  = z_lu ? 16'sd0 : signed'(to_out16(tq_q[1]));
    right_fore_torque_o  = z_rf ? 16'sd0 : signed'(to_out16(tq_q[2]));
    left_fore_torque_o   = z_lf ? 16'sd0 : signed'(to_out16(tq_q[3]));
  end

endmodule

>>> sv/agtf_checker.sv
// checker: port-level assertions for the gravity torque unit, bound to the top level
module agtf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] right_upper_torque_o,
  input logic signed [15:0] left_upper_torque_o
);

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready while result pending");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o))
    else $error("no busy period after request");

  a_ready_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> (in_ready_o && !out_valid_o))
    else $error("not ready after result taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(right_upper_torque_o) && $stable(left_upper_torque_o)))
    else $error("stalled result changed");

endmodule

bind arm_gravity_torque_feedforward_unit agtf_checker u_agtf_checker (.*);

>>> sim/arm_gravity_torque_feedforward_unit_test.sv
// testbench: gravity torque feed-forward unit against its own bit-accurate predictor
`timescale 1ns / 100ps

module arm_gravity_torque_feedforward_unit_test;
  import agtf_pkg::*;

  localparam longint TQ_LIM = 64'sd68719476735;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic signed [15:0] ru;
    logic signed [15:0] lu;
    logic signed [15:0] rf;
    logic signed [15:0] lf;
  } torque_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic hold_switch_i;
  logic [15:0] now_ms_i;
  logic signed [15:0] right_upper_angle_i, left_upper_angle_i;
  logic signed [15:0] right_fore_angle_i, left_fore_angle_i;
  logic out_valid_o, out_ready_i;
  logic signed [15:0] right_upper_torque_o, left_upper_torque_o;
  logic signed [15:0] right_fore_torque_o, left_fore_torque_o;

  arm_gravity_torque_feedforward_unit dut (.*);

  // predictor state
  logic [1:0] arm_mode, fore_prof, upper_prof;
  logic [15:0] ramp_len, g_ru, g_lu, g_rf, g_lf;
  bit ramp_on;
  logic [15:0] ramp_t0;

  torque_t torque_q[$];
  int errors = 0;
  int cycles = 0;
  logic [15:0] clock_ms = 16'd0;
  bit quiet_out = 0;

  const longint FORE_TAB[3][3] = '{'{426750, -745513, -1727177},
                                   '{339292, -534979, -1792000},
                                   '{286720, -491930, -1539500}};
  const longint UPPER_TAB[2][3] = '{'{-285118, 28095, 2474853},
                                    '{-295865, 151429, 2171781}};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clip36(longint x);
    if (x > TQ_LIM) return TQ_LIM;
    if (x < -TQ_LIM) return -TQ_LIM;
    return x;
  endfunction

  function automatic longint horner(longint c0, longint c1, longint c2, longint t);
    longint p;
    p = clip36(((c0 * t) >>> 12) + c1);
    p = clip36(((p * t) >>> 12) + c2);
    return clip36((p * t) >>> 12);
  endfunction

  function automatic longint forearm_gravity(longint t);
    int s;
    if (fore_prof < 2'd1) return 0;
    s = fore_prof - 1;
    return clip36((horner(FORE_TAB[s][0], FORE_TAB[s][1], FORE_TAB[s][2], t) * -33395) >>> 12);
  endfunction

  function automatic longint upperarm_gravity(longint fore, longint a);
    int s;
    s = (upper_prof == 2'd1) ? 0 : 1;
    return clip36(fore + clip36((horner(UPPER_TAB[s][0], UPPER_TAB[s][1],
                                        UPPER_TAB[s][2], a) * 66266) >>> 12));
  endfunction

  function automatic longint scale_gain(longint t, logic [15:0] g);
    return clip36((t * longint'({48'd0, g})) >>> 12);
  endfunction

  function automatic logic signed [15:0] to_cmd(longint t);
    longint q;
    q = t / 4096;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic torque_t predict_torques(bit hold, logic [15:0] now,
      logic signed [15:0] a_ru, logic signed [15:0] a_lu,
      logic signed [15:0] a_rf, logic signed [15:0] a_lf);
    longint tq[4];
    longint ru, lu, rf, lf, fr, fl, ur, ul;
    logic [15:0] elapsed;
    torque_t r;
    tq = '{0, 0, 0, 0};
    ru = a_ru; lu = a_lu; rf = a_rf; lf = a_lf;
    if (hold) begin
      ramp_on = 0;
    end else begin
      if (!ramp_on) begin
        ramp_t0 = now;
        ramp_on = 1;
      end
      case (arm_sel_e'(arm_mode))
        ARM_RIGHT: begin
          tq[2] = (rf >= FA_HI) ? 0 : forearm_gravity(ru + rf);
          tq[0] = (ru >= UA_HI) ? 0 : upperarm_gravity(tq[2], ru);
          tq[2] = scale_gain(tq[2], g_rf);
          tq[0] = scale_gain(tq[0], g_ru);
        end
        ARM_LEFT: begin
          tq[3] = (lf <= FA_LO) ? 0 : forearm_gravity(lu + lf);
          tq[1] = (lu <= UA_LO) ? 0 : upperarm_gravity(tq[3], lu);
          tq[3] = scale_gain(tq[3], g_lf);
          tq[1] = scale_gain(tq[1], g_lu);
        end
        ARM_BOTH: begin
          fr = forearm_gravity(ru + rf);
          fl = forearm_gravity(lu + lf);
          ur = upperarm_gravity(fr, ru);
          ul = upperarm_gravity(fl, lu);
          tq[2] = (rf >= FA_HI) ? 0 : scale_gain(fr, g_rf);
          tq[0] = (ru >= UA_HI) ? 0 : scale_gain(ur, g_ru);
          tq[3] = (lf <= FA_LO) ? 0 : scale_gain(fl, g_lf);
          tq[1] = (lu <= UA_LO) ? 0 : scale_gain(ul, g_lu);
        end
        default: ;
      endcase
      elapsed = now - ramp_t0;
      if (elapsed < ramp_len) begin
        for (int i = 0; i < 4; i++)
          tq[i] = (tq[i] * longint'({48'd0, elapsed})) / longint'({48'd0, ramp_len});
      end
    end
    r.ru = to_cmd(tq[0]);
    r.lu = to_cmd(tq[1]);
    r.rf = to_cmd(tq[2]);
    r.lf = to_cmd(tq[3]);
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 11) == 0) return $urandom_range(20, 70);
    return $urandom_range(0, 2);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    torque_t exp_t, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{right_upper_torque_o, left_upper_torque_o,
              right_fore_torque_o, left_fore_torque_o};
      if (torque_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_t = torque_q.pop_front();
        if (got.ru !== exp_t.ru) begin
          $display("%0t: right upper exp %0d got %0d", $time, exp_t.ru, got.ru);
          errors++;
        end
        if (got.lu !== exp_t.lu) begin
          $display("%0t: left upper exp %0d got %0d", $time, exp_t.lu, got.lu);
          errors++;
        end
        if (got.rf !== exp_t.rf) begin
          $display("%0t: right fore exp %0d got %0d", $time, exp_t.rf, got.rf);
          errors++;
        end
        if (got.lf !== exp_t.lf) begin
          $display("%0t: left fore exp %0d got %0d", $time, exp_t.lf, got.lf);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet_out) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
        n = pick_gap();
        if (n > 0) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL arm_gravity_torque_feedforward_unit");
      $finish;
    end
  end

  task automatic send_tick(bit hold, logic [15:0] now, logic signed [15:0] ru,
      logic signed [15:0] lu, logic signed [15:0] rf, logic signed [15:0] lf, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    hold_switch_i <= hold;
    now_ms_i <= now;
    right_upper_angle_i <= ru;
    left_upper_angle_i <= lu;
    right_fore_angle_i <= rf;
    left_fore_angle_i <= lf;
    do @(posedge clk_i); while (!in_ready_o);
    torque_q.push_back(predict_torques(hold, now, ru, lu, rf, lf));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (torque_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ARM_SELECT: arm_mode = data[1:0];
      REG_FORE_PROF:  fore_prof = data[1:0];
      REG_UPPER_PROF: upper_prof = data[1:0];
      REG_RAMP_LEN:   ramp_len = data;
      REG_GAIN_RU:    g_ru = data;
      REG_GAIN_LU:    g_lu = data;
      REG_GAIN_RF:    g_rf = data;
      default:        g_lf = data;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_tick(int gap);
    logic signed [15:0] a[4];
    bit hold;
    hold = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 19) == 0) clock_ms = 16'($urandom);
    else clock_ms = clock_ms + 16'($urandom_range(0, 4));
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0: a[i] = 16'($urandom);
        1: a[i] = 16'($urandom_range(0, 600) - 300 + ((i == 2) ? FA_HI : (i == 3) ? FA_LO :
                  (i == 0) ? UA_HI : UA_LO));
        default: a[i] = 16'($urandom_range(0, 24000) - 12000);
      endcase
    end
    send_tick(hold, clock_ms, a[0], a[1], a[2], a[3], gap);
  endtask

  task automatic test_limits();
    write_reg(REG_RAMP_LEN, 16'd0);
    send_tick(0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
    send_tick(0, 16'hffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_tick(0, 16'd5, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1);
    send_tick(0, 16'd6, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, 0);
    send_tick(0, 16'd7, 16'(UA_HI - 1), 16'(UA_LO + 1), 16'(FA_HI - 1), 16'(FA_LO + 1), 0);
    send_tick(0, 16'd8, 16'(UA_HI), 16'(UA_LO), 16'(FA_HI), 16'(FA_LO), 0);
    send_tick(0, 16'd9, 16'sd4000, -16'sd4000, 16'sd2000, 16'sd2000, 0);
    send_tick(1, 16'd10, 16'sd4000, -16'sd4000, 16'sd2000, 16'sd2000, 0);
    wait_drained();
    write_reg(REG_ARM_SELECT, 16'(ARM_RIGHT));
    send_tick(0, 16'd11, 16'sd3000, 16'sd3000, 16'(FA_HI), 16'sd3000, 0);
    send_tick(0, 16'd12, 16'sd3000, 16'sd3000, 16'sd1000, 16'sd3000, 0);
    wait_drained();
    write_reg(REG_ARM_SELECT, 16'(ARM_LEFT));
    send_tick(0, 16'd13, 16'sd3000, 16'sd3000, 16'sd3000, 16'(FA_LO), 0);
    send_tick(0, 16'd14, 16'sd3000, -16'sd3000, 16'sd3000, 16'sd3000, 0);
    wait_drained();
    write_reg(REG_ARM_SELECT, 16'(ARM_NONE));
    send_tick(0, 16'd15, 16'sd3000, -16'sd3000, 16'sd3000, 16'sd3000, 0);
    wait_drained();
  endtask

  task automatic test_soft_start();
    write_reg(REG_ARM_SELECT, 16'(ARM_BOTH));
    write_reg(REG_RAMP_LEN, 16'd10);
    send_tick(1, 16'd100, 16'sd2000, 16'sd2000, 16'sd2000, 16'sd2000, 0);
    for (int i = 0; i < 6; i++)
      send_tick(0, 16'd100 + 16'(2 * i), 16'sd2000, 16'sd2000, 16'sd2000, 16'sd2000, 0);
    wait_drained();
    write_reg(REG_RAMP_LEN, 16'hffff);
    send_tick(0, 16'hfff0, 16'sd2500, 16'sd100, 16'sd1500, 16'sd1500, 0);
    send_tick(0, 16'h0020, 16'sd2500, 16'sd100, 16'sd1500, 16'sd1500, 0);
    wait_drained();
  endtask

  task automatic test_settings_sweep();
    logic [15:0] gains[5] = '{16'd0, 16'hffff, 16'd4096, 16'd1, 16'd9000};
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_ARM_SELECT, (ph < 4) ? 16'(ph) : 16'($urandom_range(0, 2)));
      write_reg(REG_FORE_PROF, 16'(ph % 4));
      write_reg(REG_UPPER_PROF, 16'((ph + 1) % 4));
      write_reg(REG_RAMP_LEN, (ph == 3) ? 16'd1 : (ph == 7) ? 16'hffff : 16'($urandom_range(2, 200)));
      write_reg(REG_GAIN_RU, (ph < 5) ? gains[ph] : 16'($urandom));
      write_reg(REG_GAIN_LU, (ph < 5) ? gains[(ph + 1) % 5] : 16'($urandom));
      write_reg(REG_GAIN_RF, (ph < 5) ? gains[(ph + 2) % 5] : 16'($urandom));
      write_reg(REG_GAIN_LF, (ph < 5) ? gains[(ph + 3) % 5] : 16'($urandom));
      for (int i = 0; i < 52; i++)
        random_tick((ph % 3 == 2) ? 0 : pick_gap());
      wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    quiet_out = 1;
    write_reg(REG_ARM_SELECT, 16'(ARM_BOTH));
    write_reg(REG_RAMP_LEN, 16'd100);
    for (int i = 0; i < 20; i++) random_tick(0);
    wait_drained();
    quiet_out = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ARM_SELECT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    hold_switch_i = 1'b1;
    now_ms_i = '0;
    right_upper_angle_i = '0;
    left_upper_angle_i = '0;
    right_fore_angle_i = '0;
    left_fore_angle_i = '0;
    arm_mode = ARM_BOTH;
    fore_prof = 2'd3;
    upper_prof = 2'd2;
    ramp_len = 16'd100;
    g_ru = 16'd4096; g_lu = 16'd4096; g_rf = 16'd4096; g_lf = 16'd4096;
    ramp_on = 0;
    ramp_t0 = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_limits();
    test_soft_start();
    test_settings_sweep();
    test_back_to_back();
    wait_drained();
    repeat (800) @(negedge clk_i);
    if (errors == 0 && torque_q.size() == 0) begin
      $display("PASS arm_gravity_torque_feedforward_unit");
    end else begin
      $display("FAIL arm_gravity_torque_feedforward_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/agtf_pkg.sv
sv/arm_gravity_torque_feedforward_unit.sv
sv/agtf_checker.sv
sim/arm_gravity_torque_feedforward_unit_test.sv
